// ----- src/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the neighbor table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define AST_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AST_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define AST_IMP(lbl, clk, rstn, ante, cons)
`define AST_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- src/ant_pkg.sv -----
// Types, codes and constants of the aging neighbor table.
`default_nettype none

package ant_pkg;

	localparam int DEF_TABLE_DEPTH = 16;
	localparam int RESULT_CAP      = 16;
	localparam int CFG_IDX_W       = 2;

	localparam logic [15:0] STALE_AGE_RST = 16'd1000;
	localparam logic [15:0] FRESH_AGE_RST = 16'd500;

	typedef enum logic [1:0] {
		REQ_UPDATE = 2'd0,
		REQ_TICK   = 2'd1,
		REQ_PURGE  = 2'd2,
		REQ_QUERY  = 2'd3
	} req_e_t;

	typedef enum logic [2:0] {
		STS_UPDATED  = 3'd0,
		STS_INSERTED = 3'd1,
		STS_FULL     = 3'd2,
		STS_PURGED   = 3'd3,
		STS_FRESH    = 3'd4,
		STS_NONE     = 3'd5
	} status_e_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STALE_AGE = 2'd0,
		CFG_FRESH_AGE = 2'd1
	} cfg_idx_e_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_e_t;

	typedef enum logic [1:0] {
		M_UPDATE,
		M_PURGE,
		M_QCOUNT,
		M_QEMIT
	} scan_mode_e_t;

	typedef struct packed {
		logic [15:0] id;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] seen;
	} entry_t;

	typedef struct packed {
		logic shift;      // ring advances one place
		logic take_head;  // this cell is the queue tail: takes the head entry
		logic load_new;   // append a new entry here
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ----- src/aging_neighbor_table.sv -----
// Top level of the aging neighbor table: control, clock, registers and cell chain.
//
// Usage:
//  - Input channel (in_valid / in_stall): one beat is one request. Update
//    refreshes or appends a neighbor, tick advances the millisecond clock,
//    purge drops entries older than stale_age, query lists entries whose age
//    is at most fresh_age.
//  - Output channel (out_valid / out_stall): update and purge give one beat,
//    a query gives one beat per fresh entry (at most 16) or one "none fresh"
//    beat; last marks the final beat of a request. Tick gives nothing.
//  - Config channel (cfg_valid / cfg_ready, always ready): index 0 stale_age,
//    index 1 fresh_age; other indexes are ignored. Write only while idle.
//  - Timing: update and purge rotate the slot chain once, a query twice (once
//    when no entry is fresh); update and purge then give their beat once the
//    output is free. The cost is the rotation of the slot chain: one slot passes
//    the head per cycle, unless a stalled output holds the query's emit pass.
//  - in_stall is high while a request is being worked; a finished result
//    waits in the output register while the next request is taken.
//  - A stalled output holds its beat and freezes the query scan.
//  - Reset clears clock, entry count, registers to 1000 / 500 and the output.
`default_nettype none

`include "assert_macros.svh"

module aging_neighbor_table
	import ant_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// request channel
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           req_type,
	input  wire logic [15:0]          nbr_id,
	input  wire logic signed [31:0]   pos_x,
	input  wire logic signed [31:0]   pos_y,
	input  wire logic signed [31:0]   pos_z,
	// result channel
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [2:0]                status,
	output logic [15:0]               entry_id_out,
	output logic signed [31:0]        x_out,
	output logic signed [31:0]        y_out,
	output logic signed [31:0]        z_out,
	output logic [31:0]               age_out,
	output logic [4:0]                count_out,
	output logic                      last,
	// config channel
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]          cfg_data
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);

	// control state
	state_e_t     state_q, state_d;
	scan_mode_e_t mode_q, mode_d;
	logic [CW-1:0] step_q, step_d;       // slots already passed the head
	logic [CW-1:0] len_q, len_d;         // slots to scan
	logic [CW-1:0] tail_q, tail_d;       // live queue length during a scan
	logic [CW-1:0] removed_q, removed_d;
	logic [CW-1:0] fresh_n_q, fresh_n_d;
	logic [CW-1:0] emit_n_q, emit_n_d;
	logic [CW-1:0] count_q, count_d;
	logic          found_q, found_d;
	logic          ins_q, ins_d;
	logic [31:0]   clock_q, clock_d;
	logic [15:0]   stale_q, fresh_q;

	// latched request
	logic [15:0] id_q;
	logic [31:0] px_q, py_q, pz_q;

	// output register
	logic        out_valid_q;
	logic        out_load;
	status_e_t   sts_q, sts_d;
	logic [15:0] oid_q, oid_d;
	logic [31:0] ox_q, ox_d, oy_q, oy_d, oz_q, oz_d, oage_q, oage_d;
	logic [4:0]  ocnt_q, ocnt_d;
	logic        olast_q, olast_d;

	// chain
	entry_t     cell_q [TABLE_DEPTH];
	cell_ctrl_t cell_ctrl [TABLE_DEPTH];
	entry_t     head, head_wb, new_entry;

	logic        in_acc;
	logic [31:0] age;
	logic        is_stale, is_fresh, stepping, scan_end;
	logic        want_emit, out_free, adv, keep_head, match, append;
	logic [CW-1:0] emit_lim, tail_m1;

	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// head slot evaluation
	assign head     = cell_q[0];
	assign age      = clock_q - head.seen;
	assign is_stale = age > {16'd0, stale_q};
	assign is_fresh = age <= {16'd0, fresh_q};

	assign stepping = (state_q == ST_SCAN) && (step_q != len_q);
	assign scan_end = (state_q == ST_SCAN) && (step_q == len_q);

	// a query reports no more than RESULT_CAP entries
	always_comb begin
		if (32'(fresh_n_q) > RESULT_CAP) begin
			emit_lim = CW'(RESULT_CAP);
		end else begin
			emit_lim = fresh_n_q;
		end
	end

	assign out_free  = !out_valid_q || !out_stall;
	assign want_emit = (mode_q == M_QEMIT) && is_fresh && (emit_n_q != emit_lim);
	assign adv       = stepping && !(want_emit && !out_free);
	assign keep_head = !((mode_q == M_PURGE) && is_stale);
	assign match     = (mode_q == M_UPDATE) && !found_q && (head.id == id_q);
	assign append    = scan_end && (mode_q == M_UPDATE) && !found_q &&
		(32'(count_q) < TABLE_DEPTH);
	assign tail_m1   = tail_q - 1'b1;

	assign new_entry = '{id: id_q, x: px_q, y: py_q, z: pz_q, seen: clock_q};
	assign head_wb   = match ? new_entry : head;

	// cell chain: each slot takes its right neighbor, the queue tail takes the head
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		entry_t right;

		if (i == TABLE_DEPTH - 1) begin : g_end
			assign right = head_wb;
		end else begin : g_mid
			assign right = cell_q[i+1];
		end

		assign cell_ctrl[i] = '{
			shift:     adv,
			take_head: keep_head && (tail_m1 == CW'(i)),
			load_new:  append && (count_q == CW'(i))
		};

		ant_cell u_cell (
			.clk      (clk),
			.ctrl     (cell_ctrl[i]),
			.right_in (right),
			.head_in  (head_wb),
			.new_in   (new_entry),
			.q        (cell_q[i])
		);
	end

	// sequencer
	always_comb begin
		state_d   = state_q;
		mode_d    = mode_q;
		step_d    = step_q;
		len_d     = len_q;
		tail_d    = tail_q;
		removed_d = removed_q;
		fresh_n_d = fresh_n_q;
		emit_n_d  = emit_n_q;
		count_d   = count_q;
		found_d   = found_q;
		ins_d     = ins_q;
		clock_d   = clock_q;
		out_load  = 1'b0;
		sts_d     = STS_NONE;
		oid_d     = '0;
		ox_d      = '0;
		oy_d      = '0;
		oz_d      = '0;
		oage_d    = '0;
		ocnt_d    = '0;
		olast_d   = 1'b1;

		unique case (state_q)
			ST_IDLE: begin
				step_d    = '0;
				len_d     = count_q;
				tail_d    = count_q;
				removed_d = '0;
				fresh_n_d = '0;
				emit_n_d  = '0;
				found_d   = 1'b0;
				ins_d     = 1'b0;
				if (in_acc) begin
					unique case (req_e_t'(req_type))
						REQ_TICK: clock_d = clock_q + 32'd1;
						REQ_UPDATE: begin
							mode_d  = M_UPDATE;
							state_d = ST_SCAN;
						end
						REQ_PURGE: begin
							mode_d  = M_PURGE;
							state_d = ST_SCAN;
						end
						REQ_QUERY: begin
							mode_d  = M_QCOUNT;
							state_d = ST_SCAN;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end

			ST_SCAN: begin
				if (adv) begin
					step_d = step_q + 1'b1;
					unique case (mode_q)
						M_UPDATE: if (match) found_d = 1'b1;
						M_PURGE: begin
							if (is_stale) begin
								removed_d = removed_q + 1'b1;
								tail_d    = tail_q - 1'b1;
							end
						end
						M_QCOUNT: if (is_fresh) fresh_n_d = fresh_n_q + 1'b1;
						M_QEMIT: begin
							if (want_emit) begin
								emit_n_d = emit_n_q + 1'b1;
								out_load = 1'b1;
								sts_d    = STS_FRESH;
								oid_d    = head.id;
								ox_d     = head.x;
								oy_d     = head.y;
								oz_d     = head.z;
								oage_d   = age;
								olast_d  = (emit_n_q + 1'b1) == emit_lim;
							end
						end
						default: ;
					endcase
				end
				if (scan_end) begin
					unique case (mode_q)
						M_UPDATE: begin
							if (append) begin
								count_d = count_q + 1'b1;
								ins_d   = 1'b1;
							end
							state_d = ST_DONE;
						end
						M_PURGE: begin
							count_d = tail_q;
							state_d = ST_DONE;
						end
						M_QCOUNT: begin
							if (fresh_n_q == '0) begin
								state_d = ST_DONE;
							end else begin
								mode_d = M_QEMIT;
								step_d = '0;
							end
						end
						M_QEMIT: state_d = ST_IDLE;
						default: state_d = ST_IDLE;
					endcase
				end
			end

			ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
					unique case (mode_q)
						M_UPDATE: begin
							oid_d  = id_q;
							ocnt_d = 5'(count_q);
							if (found_q || ins_q) begin
								sts_d = found_q ? STS_UPDATED : STS_INSERTED;
								ox_d  = px_q;
								oy_d  = py_q;
								oz_d  = pz_q;
							end else begin
								sts_d = STS_FULL;
							end
						end
						M_PURGE: begin
							sts_d  = STS_PURGED;
							ocnt_d = 5'(removed_q);
						end
						default: sts_d = STS_NONE;
					endcase
				end
			end

			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= M_UPDATE;
			step_q      <= '0;
			len_q       <= '0;
			tail_q      <= '0;
			removed_q   <= '0;
			fresh_n_q   <= '0;
			emit_n_q    <= '0;
			count_q     <= '0;
			found_q     <= 1'b0;
			ins_q       <= 1'b0;
			clock_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			mode_q      <= mode_d;
			step_q      <= step_d;
			len_q       <= len_d;
			tail_q      <= tail_d;
			removed_q   <= removed_d;
			fresh_n_q   <= fresh_n_d;
			emit_n_q    <= emit_n_d;
			count_q     <= count_d;
			found_q     <= found_d;
			ins_q       <= ins_d;
			clock_q     <= clock_d;
			out_valid_q <= out_load || (out_valid_q && out_stall);
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stale_q <= STALE_AGE_RST;
			fresh_q <= FRESH_AGE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_e_t'(cfg_index))
				CFG_STALE_AGE: stale_q <= cfg_data;
				CFG_FRESH_AGE: fresh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// request payload, taken with the beat
	always_ff @(posedge clk) begin
		if (in_acc) begin
			id_q <= nbr_id;
			px_q <= pos_x;
			py_q <= pos_y;
			pz_q <= pos_z;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			sts_q   <= sts_d;
			oid_q   <= oid_d;
			ox_q    <= ox_d;
			oy_q    <= oy_d;
			oz_q    <= oz_d;
			oage_q  <= oage_d;
			ocnt_q  <= ocnt_d;
			olast_q <= olast_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = sts_q;
	assign entry_id_out = oid_q;
	assign x_out        = ox_q;
	assign y_out        = oy_q;
	assign z_out        = oz_q;
	assign age_out      = oage_q;
	assign count_out    = ocnt_q;
	assign last         = olast_q;

	// checks
	`AST_IMP(a_count_max, clk, arst_n, 1'b1, 32'(count_q) <= TABLE_DEPTH)
	`AST_IMP(a_tail_le_count, clk, arst_n, state_q == ST_SCAN, tail_q <= count_q)
	`AST_IMP(a_emit_cap, clk, arst_n, mode_q == M_QEMIT, emit_n_q <= emit_lim)
	`AST_NXT(a_tick, clk, arst_n, in_acc && (req_type == REQ_TICK), clock_q == $past(clock_q) + 32'd1)

endmodule

`default_nettype wire

// ----- src/ant_cell.sv -----
// One table slot of the rotating chain.
`default_nettype none

module ant_cell
	import ant_pkg::*;
(
	input  wire logic       clk,
	input  wire cell_ctrl_t ctrl,
	input  wire entry_t     right_in,
	input  wire entry_t     head_in,
	input  wire entry_t     new_in,
	output entry_t          q
);

	entry_t slot_q;

	always_ff @(posedge clk) begin
		if (ctrl.load_new) begin
			slot_q <= new_in;
		end else if (ctrl.shift) begin
			slot_q <= ctrl.take_head ? head_in : right_in;
		end
	end

	assign q = slot_q;

endmodule

`default_nettype wire

// ----- tb/tb_aging_neighbor_table.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of aging_neighbor_table: directed and random requests.
module tb_aging_neighbor_table;
	import ant_pkg::*;

	localparam int unsigned DEPTH       = DEF_TABLE_DEPTH;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	// slowest request is a query over a full table, which rotates the chain twice; plus slack
	localparam int unsigned DRAIN_GUARD = 50;
	localparam int unsigned REPORT_MAX  = 10;
	localparam int unsigned ID_POOL     = 24;
	localparam int unsigned PHASES      = 6;
	localparam int unsigned PHASE_ITEMS = 70;
	// indexes that map to no register; the block must ignore writes to them
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

	typedef struct packed {
		req_e_t      kind;
		logic [15:0] id;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} request_t;

	typedef struct packed {
		status_e_t   st;
		logic [15:0] id;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] age;
		logic [4:0]  cnt;
		logic        fin;
	} beat_t;

	// Mirror of the neighbor table plus the queue of result beats still owed.
	class neighbor_book;
		logic [15:0] stale_lim;
		logic [15:0] fresh_lim;
		logic [31:0] now_ms;
		int unsigned held;
		logic [15:0] ids  [DEPTH];
		logic [31:0] xs   [DEPTH];
		logic [31:0] ys   [DEPTH];
		logic [31:0] zs   [DEPTH];
		logic [31:0] seen [DEPTH];
		beat_t       owed [$];
		int unsigned mismatches;

		function new();
			stale_lim  = STALE_AGE_RST;
			fresh_lim  = FRESH_AGE_RST;
			now_ms     = '0;
			held       = 0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
			if (idx == CFG_STALE_AGE)
				stale_lim = val;
			else if (idx == CFG_FRESH_AGE)
				fresh_lim = val;
		endfunction

		// Apply one accepted request to the mirror and queue the beats it owes.
		function void note_request(request_t r);
			beat_t       b;
			beat_t       prev;
			bit          have_prev;
			int unsigned i;
			int unsigned hit;
			int unsigned keep;
			int unsigned removed;
			logic [31:0] age;
			b = '0;
			b.fin = 1'b1;
			case (r.kind)
			REQ_UPDATE: begin
				hit = held;
				for (i = 0; i < held; i++)
					if (hit == held && ids[i] == r.id)
						hit = i;
				b.id  = r.id;
				b.cnt = 5'(held);
				if (hit < held) begin
					xs[hit]   = r.x;
					ys[hit]   = r.y;
					zs[hit]   = r.z;
					seen[hit] = now_ms;
					b.st = STS_UPDATED;
					b.x  = r.x;
					b.y  = r.y;
					b.z  = r.z;
				end else if (held < DEPTH) begin
					ids[held]  = r.id;
					xs[held]   = r.x;
					ys[held]   = r.y;
					zs[held]   = r.z;
					seen[held] = now_ms;
					held++;
					b.st  = STS_INSERTED;
					b.x   = r.x;
					b.y   = r.y;
					b.z   = r.z;
					b.cnt = 5'(held);
				end else begin
					b.st = STS_FULL;
				end
				owed.insert(owed.size(), b);
			end
			REQ_TICK: begin
				now_ms = now_ms + 32'd1;
			end
			REQ_PURGE: begin
				keep    = 0;
				removed = 0;
				for (i = 0; i < held; i++) begin
					age = now_ms - seen[i];
					if (age > {16'd0, stale_lim}) begin
						removed++;
					end else begin
						ids[keep]  = ids[i];
						xs[keep]   = xs[i];
						ys[keep]   = ys[i];
						zs[keep]   = zs[i];
						seen[keep] = seen[i];
						keep++;
					end
				end
				held  = keep;
				b.st  = STS_PURGED;
				b.cnt = 5'(removed);
				owed.insert(owed.size(), b);
			end
			default: begin
				// query: one beat per fresh entry in table order, last flag on the final one
				hit       = 0;
				have_prev = 1'b0;
				prev      = '0;
				for (i = 0; i < held && hit < RESULT_CAP; i++) begin
					age = now_ms - seen[i];
					if (age <= {16'd0, fresh_lim}) begin
						if (have_prev)
							owed.insert(owed.size(), prev);
						prev       = '0;
						prev.st    = STS_FRESH;
						prev.id    = ids[i];
						prev.x     = xs[i];
						prev.y     = ys[i];
						prev.z     = zs[i];
						prev.age   = age;
						have_prev  = 1'b1;
						hit++;
					end
				end
				if (have_prev) begin
					prev.fin = 1'b1;
					owed.insert(owed.size(), prev);
				end else begin
					b.st = STS_NONE;
					owed.insert(owed.size(), b);
				end
			end
			endcase
		endfunction

		// Compare one accepted result beat with the oldest owed beat.
		function void check_beat(beat_t got);
			beat_t want;
			string bad;
			want = '0;
			bad  = "";
			if (owed.size() == 0) begin
				bad = " unexpected beat";
			end else begin
				want = owed.pop_front();
				if (got.st  != want.st)  bad = {bad, " status"};
				if (got.id  != want.id)  bad = {bad, " entry_id_out"};
				if (got.x   != want.x)   bad = {bad, " x_out"};
				if (got.y   != want.y)   bad = {bad, " y_out"};
				if (got.z   != want.z)   bad = {bad, " z_out"};
				if (got.age != want.age) bad = {bad, " age_out"};
				if (got.cnt != want.cnt) bad = {bad, " count_out"};
				if (got.fin != want.fin) bad = {bad, " last"};
			end
			if (bad != "") begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("[%0t] result mismatch:%s", $time, bad);
					$display("  expected st=%0d id=%h x=%h y=%h z=%h age=%0d cnt=%0d last=%b",
						want.st, want.id, want.x, want.y, want.z, want.age, want.cnt, want.fin);
					$display("  actual   st=%0d id=%h x=%h y=%h z=%h age=%0d cnt=%0d last=%b",
						got.st, got.id, got.x, got.y, got.z, got.age, got.cnt, got.fin);
				end
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         req_type = REQ_UPDATE;
	logic [15:0]        nbr_id = '0;
	logic signed [31:0] pos_x = '0;
	logic signed [31:0] pos_y = '0;
	logic signed [31:0] pos_z = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [2:0]         status;
	logic [15:0]        entry_id_out;
	logic signed [31:0] x_out;
	logic signed [31:0] y_out;
	logic signed [31:0] z_out;
	logic [31:0]        age_out;
	logic [4:0]         count_out;
	logic               last;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_STALE_AGE;
	logic [15:0]        cfg_data = '0;

	int unsigned  gap_pct = 0;    // chance per cycle that the request side holds off
	int unsigned  stall_pct = 0;  // chance per cycle that the result side stalls
	int unsigned  cycle_cnt = 0;
	logic [15:0]  id_pool [ID_POOL];
	neighbor_book book = new();

	aging_neighbor_table dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.nbr_id       (nbr_id),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.entry_id_out (entry_id_out),
		.x_out        (x_out),
		.y_out        (y_out),
		.z_out        (z_out),
		.age_out      (age_out),
		.count_out    (count_out),
		.last         (last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	// Result side: random stall, changed only on the falling edge.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Result beats are taken at the rising edge; the cycle counter bounds the run.
	always @(posedge clk) begin
		cycle_cnt = cycle_cnt + 1;
		if (arst_n && out_valid && !out_stall)
			book.check_beat({status_e_t'(status), entry_id_out, x_out, y_out, z_out,
				age_out, count_out, last});
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("aging_neighbor_table verification failed");
			$finish;
		end
	end

	function automatic request_t mk(req_e_t k, logic [15:0] id, logic [31:0] x,
		logic [31:0] y, logic [31:0] z);
		request_t r;
		r.kind = k;
		r.id   = id;
		r.x    = x;
		r.y    = y;
		r.z    = z;
		return r;
	endfunction

	// Mostly updates and ticks so ages spread out; ids mostly from a pool so refreshes happen.
	function automatic request_t rand_request();
		request_t    r;
		int unsigned pick;
		pick = $urandom_range(99);
		r.id = ($urandom_range(9) < 7) ? id_pool[$urandom_range(ID_POOL - 1)] : 16'($urandom);
		r.x  = $urandom;
		r.y  = $urandom;
		r.z  = $urandom;
		if (pick < 40)
			r.kind = REQ_UPDATE;
		else if (pick < 75)
			r.kind = REQ_TICK;
		else if (pick < 85)
			r.kind = REQ_PURGE;
		else
			r.kind = REQ_QUERY;
		return r;
	endfunction

	// Present one request beat and hold it until the block takes it.
	task automatic send_req(request_t r);
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= r.kind;
		nbr_id      <= r.id;
		pos_x       <= r.x;
		pos_y       <= r.y;
		pos_z       <= r.z;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		book.note_request(r);
	endtask

	// Stop sending, wait for every owed beat, then wait out the drain guard.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (book.owed.size() != 0)
			@(posedge clk);
		repeat (DRAIN_GUARD) @(posedge clk);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		book.write_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int unsigned k;
		int unsigned ph;
		logic [15:0] stale_set [PHASES];
		logic [15:0] fresh_set [PHASES];
		stale_set = '{16'd0, 16'hFFFF, 16'd5, 16'd12, 16'd3, 16'd40};
		fresh_set = '{16'd0, 16'hFFFF, 16'd3, 16'd6, 16'd12, 16'd20};
		for (k = 0; k < ID_POOL; k++)
			id_pool[k] = 16'($urandom);
		id_pool[0] = 16'h0000;
		id_pool[1] = 16'hFFFF;

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty table, extreme ids and positions, refresh, fill, overflow.
		send_req(mk(REQ_QUERY, 16'hFFFF, '1, '1, '1));
		send_req(mk(REQ_PURGE, 16'h0000, '0, '0, '0));
		send_req(mk(REQ_UPDATE, 16'h0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000));
		send_req(mk(REQ_UPDATE, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
		send_req(mk(REQ_TICK, 16'hA5A5, $urandom, $urandom, $urandom));
		send_req(mk(REQ_UPDATE, 16'h0000, 32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000));
		send_req(mk(REQ_QUERY, 16'h0000, '0, '0, '0));
		for (k = 0; k < DEPTH - 2; k++)
			send_req(mk(REQ_UPDATE, 16'h0100 + 16'(k), $urandom, $urandom, $urandom));
		send_req(mk(REQ_UPDATE, 16'h5A5A, $urandom, $urandom, $urandom));
		send_req(mk(REQ_UPDATE, 16'hFFFF, $urandom, $urandom, $urandom));
		send_req(mk(REQ_QUERY, 16'h0000, '0, '0, '0));

		// Random phases, each with its own age limits and one of four idle patterns.
		for (ph = 0; ph < PHASES; ph++) begin
			settle();
			write_cfg(CFG_STALE_AGE, stale_set[ph]);
			write_cfg(CFG_FRESH_AGE, fresh_set[ph]);
			if (ph == 2) begin
				write_cfg(CFG_IDX_SPARE_A, 16'($urandom));
				write_cfg(CFG_IDX_SPARE_B, 16'($urandom));
			end
			case (ph % 4)
			0: begin
				gap_pct   = 0;
				stall_pct = 0;
			end
			1: begin
				gap_pct   = 75;
				stall_pct = 0;
			end
			2: begin
				gap_pct   = 0;
				stall_pct = 75;
			end
			default: begin
				gap_pct   = 26;
				stall_pct = 26;
			end
			endcase
			for (k = 0; k < PHASE_ITEMS; k++) begin
				// mid-phase pause in phases 1 and 4: let every owed result drain before carrying on
				if (k == PHASE_ITEMS / 2 && (ph == 1 || ph == 4))
					settle();
				send_req(rand_request());
			end
		end

		settle();
		if (book.mismatches == 0 && book.owed.size() == 0)
			$display("aging_neighbor_table verification clean");
		else
			$display("aging_neighbor_table verification failed");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+src
src/ant_pkg.sv
src/ant_cell.sv
src/aging_neighbor_table.sv
tb/tb_aging_neighbor_table.sv
